// ----- hdl/string_intern_hash_table_unit_defines.svh -----
// Assertion macros for the string intern hash table unit.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef STRING_INTERN_HASH_TABLE_UNIT_DEFINES_SVH
`define STRING_INTERN_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/siht_pkg.sv -----
// Shared sizes, codes, types and fixed word table for the intern table.
// No dependencies.
package siht_pkg;

  localparam int TABLE_SLOTS   = 128;
  localparam int MAX_KEY_BYTES = 32;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int CNT_W         = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
  localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;
  localparam int HASH_W        = 32;
  localparam int FIXED_WORDS   = 10;
  localparam int CODE_W        = 4;
  localparam int KIND_W        = 3;
  localparam int OUT_SLOT_W    = 7;
  localparam logic [HASH_W-1:0] HASH_INIT = 32'd5381;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD     = 3'd0,
    KIND_FOUND    = 3'd1,
    KIND_INSERTED = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_LONG     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_COMPARE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  start;
    logic  next;
    logic  write;
    logic  load;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic overlong;
    logic fix_hit;
    logic used;
    logic match;
    logic probe_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [HASH_W-1:0]   hash;
    logic [CNT_W-1:0]    len;
    logic [KEY_BITS-1:0] key;
  } slot_t;

  // Fixed words, first byte in the low bits.
  function automatic logic [39:0] fixed_word(input logic [CODE_W-1:0] code);
    case (code)
      4'd0:    fixed_word = 40'h0000006469;
      4'd1:    fixed_word = 40'h0000637273;
      4'd2:    fixed_word = 40'h0065707974;
      4'd3:    fixed_word = 40'h00656d616e;
      4'd4:    fixed_word = 40'h0066657268;
      4'd5:    fixed_word = 40'h00676e616c;
      4'd6:    fixed_word = 40'h7373616c63;
      4'd7:    fixed_word = 40'h656c797473;
      4'd8:    fixed_word = 40'h65756c6176;
      4'd9:    fixed_word = 40'h736e6c6d78;
      default: fixed_word = 40'h0;
    endcase
  endfunction

  function automatic logic [2:0] fixed_len(input logic [CODE_W-1:0] code);
    case (code)
      4'd0:                      fixed_len = 3'd2;
      4'd1:                      fixed_len = 3'd3;
      4'd2, 4'd3, 4'd4, 4'd5:    fixed_len = 3'd4;
      4'd6, 4'd7, 4'd8, 4'd9:    fixed_len = 3'd5;
      default:                   fixed_len = 3'd0;
    endcase
  endfunction

endpackage

// ----- hdl/siht_ctrl.sv -----
// Sequencing controller of the intern table: key capture, lookup, result hand-off.
// Depends on siht_pkg.
module siht_ctrl import siht_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_last_byte,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_WORD;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last_byte) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.overlong) begin
          kind_nxt  = KIND_LONG;
          state_nxt = ST_EMIT;
        end else if (stat.fix_hit) begin
          kind_nxt  = KIND_WORD;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_COMPARE;
      ST_COMPARE: begin
        if (!stat.used) begin
          kind_nxt  = KIND_INSERTED;
          state_nxt = ST_EMIT;
        end else if (stat.match) begin
          kind_nxt  = KIND_FOUND;
          state_nxt = ST_EMIT;
        end else if (stat.probe_last) begin
          kind_nxt  = KIND_FULL;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.kind   = kind_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK:   cmd.start = !stat.overlong && !stat.fix_hit;
      ST_READ:    ;
      ST_COMPARE: begin
        cmd.write = !stat.used;
        cmd.next  = stat.used && !stat.match && !stat.probe_last;
      end
      ST_EMIT:    cmd.load = stat.out_free;
      default:    ;
    endcase
  end

endmodule

// ----- hdl/siht_datapath.sv -----
// Datapath of the intern table: key buffer, DJB2 hash, fixed word match,
// slot memory with used bits, probe pointer and output register. Depends on siht_pkg.
module siht_datapath import siht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_key_byte,
  input  logic                  in_byte_valid,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [OUT_SLOT_W-1:0] out_slot_index,
  output logic [CODE_W-1:0]     out_word_code
);

  logic [7:0]        buf_r [MAX_KEY_BYTES];
  logic [CNT_W-1:0]  count_r;
  logic              over_r;
  logic [HASH_W-1:0] hash_r;
  logic [KEY_BITS-1:0] key_m;

  logic [SLOT_W-1:0] idx_r, steps_r;
  logic [TABLE_SLOTS-1:0] used_r;
  slot_t             mem [TABLE_SLOTS];
  slot_t             rd_r;
  logic              used_q_r;

  logic              fix_hit;
  logic [CODE_W-1:0] fix_code;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     kind_out_r;
  logic [OUT_SLOT_W-1:0] slot_out_r;
  logic [CODE_W-1:0]     code_out_r;

  // Key capture and running hash; the key state returns to its reset value
  // once the result has been loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      over_r  <= 1'b0;
      hash_r  <= HASH_INIT;
    end else if (cmd.load) begin
      count_r <= '0;
      over_r  <= 1'b0;
      hash_r  <= HASH_INIT;
    end else if (cmd.accept && in_byte_valid) begin
      hash_r <= {hash_r[HASH_W-6:0], 5'b0} + hash_r + HASH_W'(in_key_byte);
      if (count_r < CNT_W'(MAX_KEY_BYTES)) begin
        count_r <= count_r + 1'b1;
      end else begin
        over_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_byte_valid && (count_r < CNT_W'(MAX_KEY_BYTES))) begin
      buf_r[count_r[KIDX_W-1:0]] <= in_key_byte;
    end
  end

  // Bytes past the key length read as zero, matching the stored padding.
  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      key_m[8*i +: 8] = (CNT_W'(i) < count_r) ? buf_r[i] : 8'h00;
    end
  end

  always_comb begin
    fix_hit  = 1'b0;
    fix_code = '0;
    for (int w = 0; w < FIXED_WORDS; w++) begin
      if (!fix_hit && (count_r == CNT_W'(fixed_len(CODE_W'(w))))
          && (key_m == KEY_BITS'(fixed_word(CODE_W'(w))))) begin
        fix_hit  = 1'b1;
        fix_code = CODE_W'(w);
      end
    end
  end

  // Probe pointer wraps naturally at the power-of-two table size.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r   <= hash_r[SLOT_W-1:0];
      steps_r <= '0;
    end else if (cmd.next) begin
      idx_r   <= idx_r + 1'b1;
      steps_r <= steps_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.write) begin
      used_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    used_q_r <= used_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[idx_r] <= '{hash: hash_r, len: count_r, key: key_m};
    end
    rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_out_r <= cmd.kind;
      slot_out_r <= ((cmd.kind == KIND_FOUND) || (cmd.kind == KIND_INSERTED))
                    ? OUT_SLOT_W'(idx_r) : '0;
      code_out_r <= (cmd.kind == KIND_WORD) ? fix_code : '0;
    end
  end

  always_comb begin
    stat.overlong   = over_r;
    stat.fix_hit    = fix_hit;
    stat.used       = used_q_r;
    stat.match      = (rd_r.hash == hash_r) && (rd_r.len == count_r) && (rd_r.key == key_m);
    stat.probe_last = (steps_r == SLOT_W'(TABLE_SLOTS - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_out_r;
  assign out_slot_index  = slot_out_r;
  assign out_word_code   = code_out_r;

endmodule

// ----- hdl/string_intern_hash_table_unit.sv -----
// Key byte transactions are taken at one per cycle while the unit is idle. After a key-ending
// transaction the unit runs the fixed word check, then a read and a compare for each table slot
// probed, then loads the result, waiting while the previous result has not been taken (a fixed
// word or an overlong key skips the probes); the next transaction is taken in the cycle after the load.
// Synchronous active-low reset empties the table at once through per-slot used bits;
// no clearing pass is needed. Depends on siht_pkg, siht_ctrl and siht_datapath.
`include "string_intern_hash_table_unit_defines.svh"
module string_intern_hash_table_unit import siht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_key_byte,
  input  logic                  in_byte_valid,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [OUT_SLOT_W-1:0] out_slot_index,
  output logic [CODE_W-1:0]     out_word_code
);

  // The controller only sequences; every piece of key and table state sits in
  // the datapath. The output register lets a fresh key stream in while the
  // previous result transaction is still waiting to be taken.
  cmd_t  cmd;
  stat_t stat;
  logic  no_slot_kind;

  siht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  siht_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key_byte     (in_key_byte),
    .in_byte_valid   (in_byte_valid),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_slot_index  (out_slot_index),
    .out_word_code   (out_word_code)
  );

  // A presented result whose kind carries no slot number.
  assign no_slot_kind = out_valid && (out_result_kind != KIND_FOUND)
                        && (out_result_kind != KIND_INSERTED);

  // An insertion must only ever land in a slot that was free.
  `SIHT_ASSERT_NOW(a_write_free, cmd.write, !stat.used)
  // A loaded result is presented on the next cycle.
  `SIHT_ASSERT_NEXT(a_load_shows, cmd.load, out_valid)
  // A slot number is only reported for found or inserted keys.
  `SIHT_ASSERT_NOW(a_slot_zero, no_slot_kind, out_slot_index == '0)

endmodule
